// ----- hdl/bus_pkg.sv -----
// Shared types, codes and constants of the bootloader upgrade sequencer.
// Used by the front, queue, back and top modules; depends on nothing else.
package bus_pkg;

  localparam int unsigned MaxRetry = 3;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_VERSION_REPLY = 3'd0,
    REG_ERASE_REPLY   = 3'd1,
    REG_FLASH_REPLY   = 3'd2,
    REG_APP_HEADER    = 3'd3,
    REG_APP_VERSION   = 3'd4,
    REG_EXP_MAJOR     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_FRAME   = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_TERM    = 2'd3
  } req_t;

  // Event classes handed from the front to the back.
  typedef enum logic [2:0] {
    EV_START   = 3'd0,
    EV_TIMEOUT = 3'd1,
    EV_TERM    = 3'd2,
    EV_VER     = 3'd3,
    EV_ERASE   = 3'd4,
    EV_FLASH   = 3'd5,
    EV_APP     = 3'd6,
    EV_OTHER   = 3'd7
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t kind;
    logic     last;
    logic     ver_skip;
    logic     ver_match;
    logic     app_ok;
  } evt_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_VER     = 6'b000010,
    ST_ERASE   = 6'b000100,
    ST_FLASH   = 6'b001000,
    ST_RESET   = 6'b010000,
    ST_CONFIRM = 6'b100000
  } stage_t;

  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_VER_REQ   = 3'd1;
  localparam logic [2:0] CMD_ERASE     = 3'd2;
  localparam logic [2:0] CMD_FLASH     = 3'd3;
  localparam logic [2:0] CMD_RESET_APP = 3'd4;
  localparam logic [2:0] CMD_APP_VER   = 3'd5;

  localparam logic [1:0] FIN_RUN   = 2'd0;
  localparam logic [1:0] FIN_OK    = 2'd1;
  localparam logic [1:0] FIN_ABORT = 2'd2;

  localparam logic [2:0] NOTE_NONE        = 3'd0;
  localparam logic [2:0] NOTE_UNREQUESTED = 3'd1;
  localparam logic [2:0] NOTE_UNSUPPORTED = 3'd2;
  localparam logic [2:0] NOTE_REFUSED     = 3'd3;
  localparam logic [2:0] NOTE_UNCHECKED   = 3'd4;
  localparam logic [2:0] NOTE_RETRYING    = 3'd5;

  localparam logic [9:0] WAIT_500  = 10'd500;
  localparam logic [9:0] WAIT_100  = 10'd100;
  localparam logic [9:0] WAIT_10   = 10'd10;
  localparam logic [9:0] WAIT_1000 = 10'd1000;
  localparam logic [9:0] WAIT_0    = 10'd0;

  localparam logic [3:0] TMO_3  = 4'd3;
  localparam logic [3:0] TMO_10 = 4'd10;
  localparam logic [3:0] TMO_1  = 4'd1;

  function automatic logic [2:0] stage_code(stage_t s);
    logic [2:0] c;
    c = 3'd0;
    unique case (s)
      ST_IDLE:    c = 3'd0;
      ST_VER:     c = 3'd1;
      ST_ERASE:   c = 3'd2;
      ST_FLASH:   c = 3'd3;
      ST_RESET:   c = 3'd4;
      ST_CONFIRM: c = 3'd5;
      default:    c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/bus_front.sv -----
// Front end: configuration registers and event classification.
// Depends on bus_pkg.
module bus_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bus_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [bus_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic [1:0]                    req_type,
  input  logic [7:0]                    frame_type,
  input  logic [7:0]                    frame_second,
  input  logic [7:0]                    frame_third,
  input  logic [7:0]                    frame_len,
  input  logic                          last_chunk_sent,
  output bus_pkg::evt_t                 evt
);

  logic [7:0] ver_code_r;
  logic [7:0] erase_code_r;
  logic [7:0] flash_code_r;
  logic [7:0] app_hdr_code_r;
  logic [7:0] app_ver_code_r;
  logic [8:0] exp_major_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_code_r     <= 8'd0;
      erase_code_r   <= 8'd1;
      flash_code_r   <= 8'd2;
      app_hdr_code_r <= 8'd3;
      app_ver_code_r <= 8'd4;
      exp_major_r    <= 9'h1FF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bus_pkg::REG_VERSION_REPLY: ver_code_r     <= cfg_wdata[7:0];
        bus_pkg::REG_ERASE_REPLY:   erase_code_r   <= cfg_wdata[7:0];
        bus_pkg::REG_FLASH_REPLY:   flash_code_r   <= cfg_wdata[7:0];
        bus_pkg::REG_APP_HEADER:    app_hdr_code_r <= cfg_wdata[7:0];
        bus_pkg::REG_APP_VERSION:   app_ver_code_r <= cfg_wdata[7:0];
        bus_pkg::REG_EXP_MAJOR:     exp_major_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    evt           = '0;
    evt.kind      = bus_pkg::EV_OTHER;
    evt.last      = last_chunk_sent;
    // A negative expected major disables the check; otherwise it fits in 8 bits.
    evt.ver_skip  = exp_major_r[8];
    evt.ver_match = !exp_major_r[8] && (frame_third == exp_major_r[7:0]);
    evt.app_ok    = (frame_len >= 8'd2) && (frame_second == app_ver_code_r);
    unique case (req_type)
      bus_pkg::REQ_START:   evt.kind = bus_pkg::EV_START;
      bus_pkg::REQ_TIMEOUT: evt.kind = bus_pkg::EV_TIMEOUT;
      bus_pkg::REQ_TERM:    evt.kind = bus_pkg::EV_TERM;
      bus_pkg::REQ_FRAME: begin
        // Equal codes resolve in this order.
        priority if (frame_type == ver_code_r)     evt.kind = bus_pkg::EV_VER;
        else if (frame_type == erase_code_r)       evt.kind = bus_pkg::EV_ERASE;
        else if (frame_type == flash_code_r)       evt.kind = bus_pkg::EV_FLASH;
        else if (frame_type == app_hdr_code_r)     evt.kind = bus_pkg::EV_APP;
        else                                       evt.kind = bus_pkg::EV_OTHER;
      end
      default: evt.kind = bus_pkg::EV_OTHER;
    endcase
  end

endmodule

// ----- hdl/bus_queue.sv -----
// Two-word queue of classified events between front and back.
// Depends on bus_pkg.
module bus_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bus_pkg::evt_t push_evt,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output bus_pkg::evt_t pop_evt
);

  bus_pkg::evt_t mem_r [bus_pkg::QDepth];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic [1:0]    count_nxt;

  assign full    = (count_r == 2'(bus_pkg::QDepth));
  assign empty   = (count_r == 2'd0);
  assign pop_evt = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    priority if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push)     count_nxt = count_r - 2'd1;
    else                       count_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_evt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");

endmodule

// ----- hdl/bus_back.sv -----
// Back end: upgrade stage registers, retry logic and the result register.
// Depends on bus_pkg.
module bus_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  bus_pkg::evt_t                 q_evt,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bus_pkg::OutDataW-1:0]  out_data
);

  bus_pkg::stage_t stage_r, stage_nxt;
  logic [2:0]      retry_r, retry_nxt;
  logic            timed_out_r, timed_out_nxt;
  logic            image_done_r, image_done_nxt;
  logic            out_valid_r;
  logic [bus_pkg::OutDataW-1:0] out_data_r;

  logic [2:0] cmd;
  logic [9:0] wait_ms;
  logic       arm;
  logic [3:0] tmo;
  logic [1:0] fin;
  logic [2:0] notice;
  logic       do_step;
  logic       do_abort;
  logic [3:0] retry_inc;

  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign retry_inc = {1'b0, retry_r} + 4'd1;

  // First pass decides what the event does; the common success step follows.
  always_comb begin
    cmd = bus_pkg::CMD_NONE; wait_ms = bus_pkg::WAIT_0; arm = 1'b0; tmo = 4'd0;
    fin = bus_pkg::FIN_RUN; notice = bus_pkg::NOTE_NONE;
    do_step = 1'b0; do_abort = 1'b0;
    stage_nxt = stage_r; retry_nxt = retry_r;
    timed_out_nxt = timed_out_r; image_done_nxt = image_done_r;

    unique case (q_evt.kind)
      bus_pkg::EV_START: do_step = (stage_r == bus_pkg::ST_IDLE);
      bus_pkg::EV_TIMEOUT: begin
        priority if (stage_r == bus_pkg::ST_IDLE) begin
        end else if (stage_r == bus_pkg::ST_RESET) begin
          do_step = 1'b1;
        end else if (retry_inc > 4'(bus_pkg::MaxRetry)) begin
          do_abort = 1'b1;
        end else begin
          retry_nxt     = (retry_inc > 4'd7) ? 3'd7 : retry_inc[2:0];
          timed_out_nxt = 1'b1;
          notice        = bus_pkg::NOTE_RETRYING;
          arm           = 1'b1;
          tmo           = bus_pkg::TMO_3;
          unique case (stage_r)
            bus_pkg::ST_VER:     cmd = bus_pkg::CMD_VER_REQ;
            bus_pkg::ST_ERASE: begin
              cmd = bus_pkg::CMD_ERASE;
              tmo = bus_pkg::TMO_10;
            end
            bus_pkg::ST_CONFIRM: cmd = bus_pkg::CMD_APP_VER;
            default:             cmd = bus_pkg::CMD_NONE;
          endcase
        end
      end
      bus_pkg::EV_TERM: begin
        if ((stage_r == bus_pkg::ST_ERASE || stage_r == bus_pkg::ST_FLASH) && !timed_out_r)
          notice = bus_pkg::NOTE_REFUSED;
        else
          do_abort = 1'b1;
      end
      bus_pkg::EV_VER: begin
        priority if (stage_r != bus_pkg::ST_VER && stage_r != bus_pkg::ST_CONFIRM) begin
          notice = bus_pkg::NOTE_UNREQUESTED;
        end else if (!q_evt.ver_skip && !q_evt.ver_match) begin
          cmd      = bus_pkg::CMD_RESET_APP;
          do_abort = 1'b1;
        end else begin
          if (q_evt.ver_skip) notice = bus_pkg::NOTE_UNCHECKED;
          do_step = 1'b1;
        end
      end
      bus_pkg::EV_ERASE: begin
        if (stage_r == bus_pkg::ST_ERASE) do_step = 1'b1;
        else notice = bus_pkg::NOTE_UNREQUESTED;
      end
      bus_pkg::EV_FLASH: begin
        if (stage_r == bus_pkg::ST_FLASH) do_step = 1'b1;
        else notice = bus_pkg::NOTE_UNREQUESTED;
      end
      bus_pkg::EV_APP: begin
        priority if (stage_r == bus_pkg::ST_RESET) do_step = 1'b1;
        else if (stage_r == bus_pkg::ST_CONFIRM)   do_step = q_evt.app_ok;
        else                                       notice = bus_pkg::NOTE_UNSUPPORTED;
      end
      default: notice = bus_pkg::NOTE_UNSUPPORTED;
    endcase

    if (do_step) begin
      retry_nxt     = 3'd0;
      timed_out_nxt = 1'b0;
      arm           = 1'b1;
      unique case (stage_r)
        bus_pkg::ST_IDLE: begin
          stage_nxt = bus_pkg::ST_VER;
          cmd = bus_pkg::CMD_VER_REQ; wait_ms = bus_pkg::WAIT_500; tmo = bus_pkg::TMO_3;
        end
        bus_pkg::ST_VER: begin
          stage_nxt = bus_pkg::ST_ERASE;
          cmd = bus_pkg::CMD_ERASE; wait_ms = bus_pkg::WAIT_100; tmo = bus_pkg::TMO_10;
        end
        bus_pkg::ST_ERASE: begin
          stage_nxt = bus_pkg::ST_FLASH;
          cmd = bus_pkg::CMD_FLASH; wait_ms = bus_pkg::WAIT_10; tmo = bus_pkg::TMO_3;
          image_done_nxt = q_evt.last;
        end
        bus_pkg::ST_FLASH: begin
          if (!image_done_r) begin
            cmd = bus_pkg::CMD_FLASH; wait_ms = bus_pkg::WAIT_10; tmo = bus_pkg::TMO_3;
            image_done_nxt = q_evt.last;
          end else begin
            stage_nxt = bus_pkg::ST_RESET;
            cmd = bus_pkg::CMD_RESET_APP; wait_ms = bus_pkg::WAIT_1000;
            tmo = bus_pkg::TMO_1;
          end
        end
        bus_pkg::ST_RESET: begin
          stage_nxt = bus_pkg::ST_CONFIRM;
          cmd = bus_pkg::CMD_APP_VER; wait_ms = bus_pkg::WAIT_500; tmo = bus_pkg::TMO_3;
        end
        default: begin
          // Confirmation accepted: the upgrade is done.
          arm      = 1'b0;
          fin      = bus_pkg::FIN_OK;
          do_abort = 1'b0;
        end
      endcase
    end

    if (do_abort) fin = bus_pkg::FIN_ABORT;
    if (fin != bus_pkg::FIN_RUN) begin
      stage_nxt      = bus_pkg::ST_IDLE;
      retry_nxt      = 3'd0;
      timed_out_nxt  = 1'b0;
      image_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r      <= bus_pkg::ST_IDLE;
      retry_r      <= 3'd0;
      timed_out_r  <= 1'b0;
      image_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        stage_r      <= stage_nxt;
        retry_r      <= retry_nxt;
        timed_out_r  <= timed_out_nxt;
        image_done_r <= image_done_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= {3'd0, notice, retry_nxt, bus_pkg::stage_code(stage_nxt), fin,
                     tmo, arm, wait_ms, cmd};
    end
  end

  a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r <= 3'(bus_pkg::MaxRetry))
    else $error("retry count above limit");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && fin != bus_pkg::FIN_RUN |=> stage_r == bus_pkg::ST_IDLE && retry_r == 3'd0)
    else $error("finish did not return to idle");

  a_timer_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && !arm |-> tmo == 4'd0)
    else $error("timeout given without arming");

endmodule

// ----- hdl/bootloader_upgrade_sequencer_core.sv -----
// Top level of the bootloader upgrade sequencer: front, event queue and back.
// Depends on bus_pkg, bus_front, bus_queue and bus_back.
//
//  Port group | Dir | Contents
//  in_*       | in  | event word: tuser = req_type, tdata = frame bytes, tlast = last chunk flag
//  out_*      | out | result word: command, wait, timer, finish, stage, retries, notice
//  cfg_*      | in  | register writes, index 0..5, no read-back
//
// One event is taken per cycle and one result leaves per cycle when out_tready is high.
// Each event is written into the queue first; once the output is free, its result is
// registered. The two-word queue lets input run on while the result is stalled.
// Reset is synchronous and restores the default reply codes and the idle stage.
module bootloader_upgrade_sequencer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] frame_type, [15:8] frame_second, [23:16] frame_third, [31:24] frame_len
  input  logic [bus_pkg::InDataW-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [bus_pkg::InUserW-1:0]   in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] command, [12:3] wait_ms, [13] timer_arm, [17:14] timer_s, [19:18] finish,
  // [22:20] stage_now, [25:23] retries, [28:26] notice, rest zero
  output logic [bus_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_we,
  input  logic [bus_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [bus_pkg::CfgDataW-1:0]  cfg_wdata
);

  bus_pkg::evt_t front_evt;
  bus_pkg::evt_t q_evt;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          push;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  bus_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .req_type        (in_tuser[1:0]),
    .frame_type      (in_tdata[7:0]),
    .frame_second    (in_tdata[15:8]),
    .frame_third     (in_tdata[23:16]),
    .frame_len       (in_tdata[31:24]),
    .last_chunk_sent (in_tlast),
    .evt             (front_evt)
  );

  bus_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (front_evt),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_evt  (q_evt)
  );

  bus_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_evt     (q_evt),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for bootloader_upgrade_sequencer_core: directed and random
// upgrade sessions, a built-in predictor of the stage machine, random stalls on both sides.
// Depends on bus_pkg and the RTL under hdl only.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [2:0] {
    UP_IDLE    = 3'd0,
    UP_VERSION = 3'd1,
    UP_ERASE   = 3'd2,
    UP_FLASH   = 3'd3,
    UP_RESET   = 3'd4,
    UP_CONFIRM = 3'd5
  } upgrade_stage_t;

  // Field order follows {in_tlast, in_tdata} from the top bit down to bit 0.
  typedef struct packed {
    logic       last;
    logic [7:0] len;
    logic [7:0] third;
    logic [7:0] second;
    logic [7:0] ftype;
  } frame_word_t;

  typedef struct packed {
    bus_pkg::req_t req;
    frame_word_t   frame;
  } upgrade_event_t;

  // Field order follows out_tdata from bit 28 down to bit 0.
  typedef struct packed {
    logic [2:0] notice;
    logic [2:0] retries;
    logic [2:0] stage_now;
    logic [1:0] finish;
    logic [3:0] timer_s;
    logic       timer_arm;
    logic [9:0] wait_ms;
    logic [2:0] command;
  } seq_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [bus_pkg::InDataW-1:0]   in_tdata = '0;
  logic [bus_pkg::InUserW-1:0]   in_tuser = '0;
  logic                          in_tlast = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [bus_pkg::OutDataW-1:0]  out_tdata;
  logic                          cfg_we = 1'b0;
  logic [bus_pkg::CfgAddrW-1:0]  cfg_addr = '0;
  logic [bus_pkg::CfgDataW-1:0]  cfg_wdata = '0;

  bootloader_upgrade_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register shadows, starting at their reset values.
  logic [7:0] code_ver     = 8'd0;
  logic [7:0] code_erase   = 8'd1;
  logic [7:0] code_flash   = 8'd2;
  logic [7:0] code_app     = 8'd3;
  logic [7:0] code_app_ver = 8'd4;
  logic [8:0] need_major   = 9'h1FF;

  // Predicted sequencer state.
  upgrade_stage_t stg = UP_IDLE;
  logic [2:0]     retry_cnt = 3'd0;
  logic           timed_out_q = 1'b0;
  logic           image_done_q = 1'b0;

  upgrade_event_t pending_events[$];
  seq_result_t    upgrade_results[$];

  int items_queued = 0;
  int events_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int upgrades_done = 0;
  int upgrades_aborted = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int rx_hold_left = 0;
  bit in_word_taken = 1'b0;

  function automatic void reset_progress();
    stg = UP_IDLE;
    retry_cnt = 3'd0;
    timed_out_q = 1'b0;
    image_done_q = 1'b0;
  endfunction

  function automatic void arm_timer(inout seq_result_t r, input logic [2:0] cmd,
                                    input logic [9:0] wait_v, input logic [3:0] tmo);
    r.command = cmd;
    r.wait_ms = wait_v;
    r.timer_arm = 1'b1;
    r.timer_s = tmo;
  endfunction

  // A successful step: clears the retry state and moves the upgrade on.
  function automatic void advance_stage(inout seq_result_t r, input logic last);
    retry_cnt = 3'd0;
    timed_out_q = 1'b0;
    case (stg)
      UP_IDLE: begin
        stg = UP_VERSION;
        arm_timer(r, bus_pkg::CMD_VER_REQ, bus_pkg::WAIT_500, bus_pkg::TMO_3);
      end
      UP_VERSION: begin
        stg = UP_ERASE;
        arm_timer(r, bus_pkg::CMD_ERASE, bus_pkg::WAIT_100, bus_pkg::TMO_10);
      end
      UP_ERASE: begin
        stg = UP_FLASH;
        arm_timer(r, bus_pkg::CMD_FLASH, bus_pkg::WAIT_10, bus_pkg::TMO_3);
        image_done_q = last;
      end
      UP_FLASH: begin
        if (!image_done_q) begin
          arm_timer(r, bus_pkg::CMD_FLASH, bus_pkg::WAIT_10, bus_pkg::TMO_3);
          image_done_q = last;
        end else begin
          stg = UP_RESET;
          arm_timer(r, bus_pkg::CMD_RESET_APP, bus_pkg::WAIT_1000, bus_pkg::TMO_1);
        end
      end
      UP_RESET: begin
        stg = UP_CONFIRM;
        arm_timer(r, bus_pkg::CMD_APP_VER, bus_pkg::WAIT_500, bus_pkg::TMO_3);
      end
      UP_CONFIRM: begin
        r.finish = bus_pkg::FIN_OK;
        reset_progress();
      end
      default: ;
    endcase
  endfunction

  function automatic seq_result_t advance_upgrade(upgrade_event_t ev);
    seq_result_t r;
    frame_word_t f;
    logic [3:0]  next_retry;
    r = '0;
    f = ev.frame;
    case (ev.req)
      bus_pkg::REQ_START: begin
        if (stg == UP_IDLE) advance_stage(r, f.last);
      end
      bus_pkg::REQ_FRAME: begin
        // Reply codes may be equal; the first match in this order wins.
        if (f.ftype == code_ver) begin
          if (stg != UP_VERSION && stg != UP_CONFIRM) begin
            r.notice = bus_pkg::NOTE_UNREQUESTED;
          end else if (!need_major[8] && {1'b0, f.third} != need_major) begin
            r.command = bus_pkg::CMD_RESET_APP;
            r.finish = bus_pkg::FIN_ABORT;
            reset_progress();
          end else begin
            if (need_major[8]) r.notice = bus_pkg::NOTE_UNCHECKED;
            advance_stage(r, f.last);
          end
        end else if (f.ftype == code_erase) begin
          if (stg == UP_ERASE) advance_stage(r, f.last);
          else r.notice = bus_pkg::NOTE_UNREQUESTED;
        end else if (f.ftype == code_flash) begin
          if (stg == UP_FLASH) advance_stage(r, f.last);
          else r.notice = bus_pkg::NOTE_UNREQUESTED;
        end else if (f.ftype == code_app && stg == UP_RESET) begin
          advance_stage(r, f.last);
        end else if (f.ftype == code_app && stg == UP_CONFIRM) begin
          // Anything but a version response is dropped without a notice.
          if (f.len >= 8'd2 && f.second == code_app_ver) advance_stage(r, f.last);
        end else begin
          r.notice = bus_pkg::NOTE_UNSUPPORTED;
        end
      end
      bus_pkg::REQ_TIMEOUT: begin
        if (stg == UP_RESET) begin
          advance_stage(r, f.last);
        end else if (stg != UP_IDLE) begin
          next_retry = {1'b0, retry_cnt} + 4'd1;
          if (next_retry > 4'(bus_pkg::MaxRetry)) begin
            r.finish = bus_pkg::FIN_ABORT;
            reset_progress();
          end else begin
            retry_cnt = (next_retry > 4'd7) ? 3'd7 : next_retry[2:0];
            timed_out_q = 1'b1;
            r.notice = bus_pkg::NOTE_RETRYING;
            case (stg)
              UP_VERSION: arm_timer(r, bus_pkg::CMD_VER_REQ, bus_pkg::WAIT_0, bus_pkg::TMO_3);
              UP_ERASE:   arm_timer(r, bus_pkg::CMD_ERASE, bus_pkg::WAIT_0, bus_pkg::TMO_10);
              UP_FLASH:   arm_timer(r, bus_pkg::CMD_NONE, bus_pkg::WAIT_0, bus_pkg::TMO_3);
              UP_CONFIRM: arm_timer(r, bus_pkg::CMD_APP_VER, bus_pkg::WAIT_0, bus_pkg::TMO_3);
              default: ;
            endcase
          end
        end
      end
      default: begin
        if ((stg == UP_ERASE || stg == UP_FLASH) && !timed_out_q) begin
          r.notice = bus_pkg::NOTE_REFUSED;
        end else begin
          r.finish = bus_pkg::FIN_ABORT;
          reset_progress();
        end
      end
    endcase
    r.stage_now = stg;
    r.retries = retry_cnt;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_event(bus_pkg::req_t req, logic [7:0] ftype, logic [7:0] second,
                            logic [7:0] third, logic [7:0] len, logic last);
    upgrade_event_t ev;
    ev.req = req;
    ev.frame = '{last: last, len: len, third: third, second: second, ftype: ftype};
    pending_events.push_back(ev);
    items_queued++;
  endtask

  // Non-frame events carry random frame bytes that the block must ignore.
  task automatic push_plain(bus_pkg::req_t req);
    push_event(req, rnd8(), rnd8(), rnd8(), rnd8(), 1'($urandom));
  endtask

  task automatic maybe_disturb();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) push_plain(bus_pkg::REQ_TIMEOUT);
    else if (pick < 13) push_plain(bus_pkg::REQ_TERM);
    else if (pick < 18) push_event(bus_pkg::REQ_FRAME, rnd8(), rnd8(), rnd8(), rnd8(),
                                   1'($urandom));
    else if (pick < 20) push_plain(bus_pkg::REQ_START);
    else if (pick < 23) repeat (4) push_plain(bus_pkg::REQ_TIMEOUT);
  endtask

  // One upgrade as a well-behaved bootloader would answer it, with disturbances mixed in.
  task automatic queue_session();
    int         chunks;
    int         i;
    logic [7:0] major_byte;
    chunks = $urandom_range(1, 5);
    push_plain(bus_pkg::REQ_START);
    maybe_disturb();
    major_byte = (need_major[8] || $urandom_range(0, 7) == 0) ? rnd8() : need_major[7:0];
    push_event(bus_pkg::REQ_FRAME, code_ver, rnd8(), major_byte, rnd8(), 1'($urandom));
    maybe_disturb();
    push_event(bus_pkg::REQ_FRAME, code_erase, rnd8(), rnd8(), rnd8(), chunks == 1);
    for (i = 2; i <= chunks; i++) begin
      maybe_disturb();
      push_event(bus_pkg::REQ_FRAME, code_flash, rnd8(), rnd8(), rnd8(), i == chunks);
    end
    maybe_disturb();
    push_event(bus_pkg::REQ_FRAME, code_flash, rnd8(), rnd8(), rnd8(), 1'($urandom));
    maybe_disturb();
    if ($urandom_range(0, 1) == 0) push_plain(bus_pkg::REQ_TIMEOUT);
    else push_event(bus_pkg::REQ_FRAME, code_app, rnd8(), rnd8(), rnd8(), 1'($urandom));
    maybe_disturb();
    if ($urandom_range(0, 3) == 0)
      push_event(bus_pkg::REQ_FRAME, code_app, rnd8(), rnd8(),
                 8'($urandom_range(0, 1)), 1'($urandom));
    push_event(bus_pkg::REQ_FRAME, code_app, code_app_ver, rnd8(),
               8'($urandom_range(2, 255)), 1'($urandom));
  endtask

  task automatic configure(input logic [8:0] vals [6]);
    int i;
    for (i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= bus_pkg::reg_idx_t'(i);
      cfg_wdata <= vals[i];
      case (bus_pkg::reg_idx_t'(i))
        bus_pkg::REG_VERSION_REPLY: code_ver = vals[i][7:0];
        bus_pkg::REG_ERASE_REPLY:   code_erase = vals[i][7:0];
        bus_pkg::REG_FLASH_REPLY:   code_flash = vals[i][7:0];
        bus_pkg::REG_APP_HEADER:    code_app = vals[i][7:0];
        bus_pkg::REG_APP_VERSION:   code_app_ver = vals[i][7:0];
        default:                    need_major = vals[i];
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (events_taken != items_queued || upgrade_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Sender: holds a word until it is taken, then offers the next one or idles.
  always @(negedge clk) begin
    upgrade_event_t ev;
    if (rst_n && (!in_tvalid || in_word_taken)) begin
      if (pending_events.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        ev = pending_events.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {ev.frame.len, ev.frame.third, ev.frame.second, ev.frame.ftype};
        in_tlast <= ev.frame.last;
        in_tuser <= ev.req;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    out_tready <= rst_n && rx_hold_left == 0 && $urandom_range(0, 99) >= rx_stall_pct;

  // Long receiver hold-off, started on request from the stimulus.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      rx_hold_left = HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
    end
  end

  always @(posedge clk) begin
    seq_result_t want;
    seq_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = seq_result_t'(out_tdata[$bits(seq_result_t)-1:0]);
        results_seen++;
        if (upgrade_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = upgrade_results.pop_front();
          compare_field("command", 32'(want.command), 32'(got.command));
          compare_field("wait_ms", 32'(want.wait_ms), 32'(got.wait_ms));
          compare_field("timer_arm", 32'(want.timer_arm), 32'(got.timer_arm));
          compare_field("timer_s", 32'(want.timer_s), 32'(got.timer_s));
          compare_field("finish", 32'(want.finish), 32'(got.finish));
          compare_field("stage_now", 32'(want.stage_now), 32'(got.stage_now));
          compare_field("retries", 32'(want.retries), 32'(got.retries));
          compare_field("notice", 32'(want.notice), 32'(got.notice));
          compare_field("padding", 32'd0,
                        32'(out_tdata[bus_pkg::OutDataW-1:$bits(seq_result_t)]));
          if (want.finish == bus_pkg::FIN_OK) upgrades_done++;
          else if (want.finish == bus_pkg::FIN_ABORT) upgrades_aborted++;
        end
      end
      in_word_taken = in_tvalid && in_tready;
      if (in_word_taken) begin
        upgrade_results.push_back(advance_upgrade(
            '{req: bus_pkg::req_t'(in_tuser), frame: frame_word_t'({in_tlast, in_tdata})}));
        events_taken++;
      end
    end else begin
      in_word_taken = 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, upgrade_results.size());
      $display("** bootloader_upgrade_sequencer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [8:0] setting [6];
    int         p;
    int         m;
    int         target;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk through the stages with the reset register values.
    push_event(bus_pkg::REQ_TIMEOUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_event(bus_pkg::REQ_TERM, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_event(bus_pkg::REQ_FRAME, 8'd1, 8'h00, 8'h00, 8'h00, 1'b0);
    push_event(bus_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_plain(bus_pkg::REQ_START);
    push_plain(bus_pkg::REQ_START);
    push_plain(bus_pkg::REQ_TIMEOUT);
    push_plain(bus_pkg::REQ_TERM);
    push_plain(bus_pkg::REQ_START);
    push_event(bus_pkg::REQ_FRAME, 8'd0, 8'h00, 8'hFF, 8'hFF, 1'b0);
    push_plain(bus_pkg::REQ_TERM);
    push_plain(bus_pkg::REQ_TIMEOUT);
    push_event(bus_pkg::REQ_FRAME, 8'd1, 8'hFF, 8'h00, 8'd0, 1'b0);
    push_plain(bus_pkg::REQ_TIMEOUT);
    push_plain(bus_pkg::REQ_TERM);
    push_plain(bus_pkg::REQ_START);
    push_event(bus_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd2, 8'd3, 1'b1);
    push_event(bus_pkg::REQ_FRAME, 8'd1, 8'd0, 8'd0, 8'd1, 1'b1);
    push_event(bus_pkg::REQ_FRAME, 8'd2, 8'd0, 8'd0, 8'd1, 1'b0);
    push_plain(bus_pkg::REQ_TIMEOUT);
    push_event(bus_pkg::REQ_FRAME, 8'd3, 8'd4, 8'd0, 8'd1, 1'b0);
    push_event(bus_pkg::REQ_FRAME, 8'd3, 8'd5, 8'd0, 8'd2, 1'b0);
    push_plain(bus_pkg::REQ_TIMEOUT);
    push_event(bus_pkg::REQ_FRAME, 8'd0, 8'd1, 8'd9, 8'd3, 1'b0);
    push_plain(bus_pkg::REQ_START);
    repeat (4) push_plain(bus_pkg::REQ_TIMEOUT);
    wait_drained();

    for (p = 0; p < 5; p++) begin
      case (p)
        0: setting = '{9'h000, 9'h0FF, 9'h080, 9'h07F, 9'h000, 9'h000};
        1: setting = '{9'h1FF, 9'h100, 9'h055, 9'h0AA, 9'h1FF, 9'h0FF};
        2: setting = '{9'h05A, 9'h05A, 9'h05A, 9'h05A, 9'h0C3, 9'h1FF};
        3: setting = '{9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
                       9'($urandom), 9'($urandom_range(0, 255))};
        default: setting = '{9'd3, 9'd2, 9'd1, 9'd0, 9'($urandom),
                             ($urandom_range(0, 2) == 0) ? 9'h1FF : 9'($urandom_range(0, 15))};
      endcase
      configure(setting);
      for (m = 0; m < 4; m++) begin
        case (m)
          0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
          1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
          2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
          default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
        endcase
        // The receiver blocks while the sender keeps pushing, so the queue backs up.
        if (p == 0 && m == 0) hold_requests++;
        target = items_queued + 22;
        while (items_queued < target) queue_session();
        wait_drained();
      end
    end

    repeat (10) @(negedge clk);
    $display("Checked %0d events and %0d results across six register settings.",
             events_taken, results_seen);
    $display("Upgrades completed: %0d, aborted: %0d, field mismatches: %0d.",
             upgrades_done, upgrades_aborted, mismatches);
    if (mismatches == 0)
      $display("** bootloader_upgrade_sequencer_core: PASSED **");
    else
      $display("** bootloader_upgrade_sequencer_core: FAILED **");
    $finish;
  end

endmodule
